@@ src/sdtq_pkg.sv @@
package sdtq_pkg;

	typedef enum logic [1:0] {
		CMD_SUBMIT = 2'd0,
		CMD_HEAD   = 2'd1,
		CMD_TAIL   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int unsigned KEY_W = 16;
	localparam int unsigned TAG_W = 16;
	localparam int unsigned OCC_W = 5;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] task_len;
		logic [TAG_W-1:0] task_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [KEY_W-1:0] out_duration;
		logic [TAG_W-1:0] out_tag;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic             submit;
		logic             head;
		logic             tail;
		logic             head_win;
		logic [KEY_W-1:0] dur;
		logic [TAG_W-1:0] tag;
	} cell_ctl_t;

endpackage

@@ src/sdtq_cell.sv @@
module sdtq_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sdtq_pkg::cell_ctl_t      ctl,
	input  logic                     left_valid,
	input  logic                     left_le,
	input  logic [sdtq_pkg::KEY_W-1:0] left_key,
	input  logic [sdtq_pkg::TAG_W-1:0] left_tag,
	input  logic                     right_valid,
	input  logic [sdtq_pkg::KEY_W-1:0] right_key,
	input  logic [sdtq_pkg::TAG_W-1:0] right_tag,
	output logic                     valid,
	output logic                     le,
	output logic                     last,
	output logic [sdtq_pkg::KEY_W-1:0] key,
	output logic [sdtq_pkg::TAG_W-1:0] tag
);
	import sdtq_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;

	// entry stays ahead of the new task
	assign le    = valid_q && (key_q <= ctl.dur) && !ctl.head_win;
	assign last  = valid_q && !right_valid;
	assign valid = valid_q;
	assign key   = key_q;
	assign tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.submit) begin
			valid_q <= valid_q || left_valid;
		end else if (ctl.head) begin
			valid_q <= right_valid;
		end else if (ctl.tail) begin
			valid_q <= valid_q && right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.submit && !le) begin
			if (left_le) begin
				key_q <= ctl.dur;
				tag_q <= ctl.tag;
			end else begin
				key_q <= left_key;
				tag_q <= left_tag;
			end
		end else if (ctl.head) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end
	end

endmodule

@@ src/sorted_double_ended_task_queue.sv @@
// a response is registered in rsp when its request is taken and shows there in the next cycle
// throughput: one request per cycle while rsp is not stalled; every cell compares and shifts in the same cycle
// a new request is taken while rsp is empty or being taken, so stall on rsp stalls req
// reset (arst_n low) clears the entry count, every cell's valid bit and the rsp valid flag
// stored durations and tags are not reset; only valid cells are ever read
module sorted_double_ended_task_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sdtq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sdtq_pkg::rsp_t rsp
);
	import sdtq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	// row of cells, slot 0 is the head (shortest task)
	logic [DEPTH-1:0] c_valid;
	logic [DEPTH-1:0] c_le;
	logic [DEPTH-1:0] c_last;
	logic [KEY_W-1:0] c_key [DEPTH];
	logic [TAG_W-1:0] c_tag [DEPTH];

	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          take;
	logic          empty;
	logic          full;
	cell_ctl_t     ctl;
	logic [KEY_W-1:0] tail_key;
	logic [TAG_W-1:0] tail_tag;
	logic [CW-1:0]    count_d;
	rsp_t             rsp_d;

	// output register frees up when its response is taken
	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));

	// commands broadcast to the row; a rejected request never touches the cells
	always_comb begin
		ctl.submit   = take && (req.command == CMD_SUBMIT) && !full;
		ctl.head     = take && (req.command == CMD_HEAD) && !empty;
		ctl.tail     = take && (req.command == CMD_TAIL) && !empty;
		ctl.dur      = req.task_len;
		ctl.tag      = req.task_tag;
		// new task not longer than the head goes in front, even ahead of equal keys
		ctl.head_win = !c_valid[0] || (req.task_len <= c_key[0]);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             lv, lle, rv;
		logic [KEY_W-1:0] lk, rk;
		logic [TAG_W-1:0] lt, rt;

		if (i == 0) begin : g_first
			// the head slot sees an always-valid, always-ahead neighbor on its left
			assign lv  = 1'b1;
			assign lle = 1'b1;
			assign lk  = '0;
			assign lt  = '0;
		end else begin : g_mid
			assign lv  = c_valid[i-1];
			assign lle = c_le[i-1];
			assign lk  = c_key[i-1];
			assign lt  = c_tag[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign rv = 1'b0;
			assign rk = '0;
			assign rt = '0;
		end else begin : g_inner
			assign rv = c_valid[i+1];
			assign rk = c_key[i+1];
			assign rt = c_tag[i+1];
		end

		sdtq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_valid  (lv),
			.left_le     (lle),
			.left_key    (lk),
			.left_tag    (lt),
			.right_valid (rv),
			.right_key   (rk),
			.right_tag   (rt),
			.valid       (c_valid[i]),
			.le          (c_le[i]),
			.last        (c_last[i]),
			.key         (c_key[i]),
			.tag         (c_tag[i])
		);
	end

	// at most one cell (exactly one when not empty) flags itself as the tail, so an and-or picks it
	always_comb begin
		tail_key = '0;
		tail_tag = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_key = tail_key | (c_key[i] & {KEY_W{c_last[i]}});
			tail_tag = tail_tag | (c_tag[i] & {TAG_W{c_last[i]}});
		end
	end

	always_comb begin
		count_d            = count_q;
		rsp_d.status       = ST_DONE;
		rsp_d.out_duration = '0;
		rsp_d.out_tag      = '0;
		case (req.command)
			CMD_SUBMIT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			CMD_HEAD: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					count_d            = count_q - 1'b1;
					rsp_d.out_duration = c_key[0];
					rsp_d.out_tag      = c_tag[0];
				end
			end
			CMD_TAIL: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					count_d            = count_q - 1'b1;
					rsp_d.out_duration = tail_key;
					rsp_d.out_tag      = tail_tag;
				end
			end
			default: begin
				// unused code: no change
			end
		endcase
		rsp_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count tracks the valid bits of the row
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(c_valid) == 32'(count_q))
		else $error("entry count disagrees with cell valid bits");

	// occupied cells form an unbroken run from the head
	assert property (@(posedge clk) disable iff (!arst_n)
		((c_valid + 1'b1) & c_valid) == '0)
		else $error("gap in occupied cells");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// a taken request always leaves a response in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid_q)
		else $error("request taken without response");

endmodule

@@ sim/tb_sorted_double_ended_task_queue.sv @@
module tb_sorted_double_ended_task_queue;
	import sdtq_pkg::*;

	localparam int unsigned QDEPTH     = 16;
	localparam int unsigned CYCLE_CAP  = 400000;
	localparam int unsigned PHASE_REQS = 210;
	localparam int unsigned HOLD_REQS  = 40;
	localparam int unsigned HOLD_LEN   = 150;
	// command code with no meaning; the queue must leave its contents alone
	localparam logic [1:0]  CMD_UNUSED = 2'd3;

	// one row of the directed walk: reps copies of a request, optionally with a
	// result known up front instead of the one the shadow queue works out
	typedef struct {
		req_t        req;
		int unsigned reps;
		bit          pinned;
		rsp_t        rsp;
	} plan_row_t;

	// per-request note: carries a known result into the scoreboard
	typedef struct {
		bit   pinned;
		rsp_t rsp;
	} note_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow copy of the queue contents, head at slot 0
	logic [KEY_W-1:0] shadow_dur [QDEPTH];
	logic [TAG_W-1:0] shadow_tag [QDEPTH];
	int unsigned      shadow_held = 0;

	rsp_t  reply_q [$];
	note_t note_q [$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	plan_row_t plan [16];

	sorted_double_ended_task_queue #(
		.DEPTH(QDEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// apply one request to the shadow queue and return the result it should give
	function automatic rsp_t next_reply(input req_t r);
		rsp_t        o;
		int unsigned slot;
		o = '0;
		o.status = ST_DONE;
		if (r.command == CMD_SUBMIT) begin
			if (shadow_held >= QDEPTH) begin
				o.status = ST_FULL;
			end else begin
				// ties with the head go in front, other ties go behind equal keys
				slot = 0;
				if (shadow_held != 0 && r.task_len > shadow_dur[0]) begin
					for (int i = 0; i < shadow_held; i++) begin
						if (shadow_dur[i] <= r.task_len)
							slot = i + 1;
					end
				end
				for (int i = shadow_held; i > slot; i--) begin
					shadow_dur[i] = shadow_dur[i-1];
					shadow_tag[i] = shadow_tag[i-1];
				end
				shadow_dur[slot] = r.task_len;
				shadow_tag[slot] = r.task_tag;
				shadow_held++;
			end
		end else if (r.command == CMD_HEAD) begin
			if (shadow_held == 0) begin
				o.status = ST_EMPTY;
			end else begin
				o.out_duration = shadow_dur[0];
				o.out_tag      = shadow_tag[0];
				for (int i = 0; i + 1 < shadow_held; i++) begin
					shadow_dur[i] = shadow_dur[i+1];
					shadow_tag[i] = shadow_tag[i+1];
				end
				shadow_held--;
			end
		end else if (r.command == CMD_TAIL) begin
			if (shadow_held == 0) begin
				o.status = ST_EMPTY;
			end else begin
				// work stealing takes the longest task
				shadow_held--;
				o.out_duration = shadow_dur[shadow_held];
				o.out_tag      = shadow_tag[shadow_held];
			end
		end
		o.occupancy = shadow_held[OCC_W-1:0];
		return o;
	endfunction

	task automatic log_mismatch(input string why, input rsp_t got, input rsp_t want);
		if (mismatches < 10) begin
			$display("mismatch (%s) at cycle %0d: got st=%0d dur=%h tag=%h occ=%0d",
				why, cycles, got.status, got.out_duration, got.out_tag, got.occupancy);
			$display("  want st=%0d dur=%h tag=%h occ=%0d",
				want.status, want.out_duration, want.out_tag, want.occupancy);
		end
		mismatches++;
	endtask

	// offer one request, with a random number of idle cycles in front of it,
	// and hold it steady until the queue takes it
	task automatic offer(input req_t r, input bit pinned, input rsp_t want);
		note_t n;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		n.pinned = pinned;
		n.rsp    = want;
		note_q.push_back(n);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// cycle budget; a hang anywhere ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("tb_sorted_double_ended_task_queue: errors");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off whenever the stimulus asks
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// scoreboard: every accepted request queues its result, every accepted
	// response is checked against the oldest one still waiting
	always @(posedge clk) begin : scoreboard
		note_t n;
		rsp_t  guess;
		rsp_t  want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				n     = note_q.pop_front();
				guess = next_reply(req);
				reply_q.push_back(n.pinned ? n.rsp : guess);
			end
			if (rsp_valid && !rsp_stall) begin
				if (reply_q.size() == 0) begin
					log_mismatch("no request pending", rsp, '0);
				end else begin
					want = reply_q.pop_front();
					if (rsp.status !== want.status || rsp.out_duration !== want.out_duration
						|| rsp.out_tag !== want.out_tag || rsp.occupancy !== want.occupancy)
						log_mismatch("field", rsp, want);
				end
			end
		end
	end

	initial begin
		req_t        r;
		int unsigned fill_pct;
		int unsigned pick;
		int unsigned idle_tab [4];
		int unsigned stall_tab [4];

		// directed walk: empty fetches, unused code, extreme keys, ties with
		// the head and behind equal keys, fill to the brim and a submit when full
		plan = '{
			'{'{CMD_HEAD,   16'h0000, 16'h0000}, 1,  1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 5'd0}},
			'{'{CMD_TAIL,   16'h0000, 16'h0000}, 1,  1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 5'd0}},
			'{'{CMD_UNUSED, 16'hFFFF, 16'hFFFF}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
			'{'{CMD_SUBMIT, 16'hFFFF, 16'hFFFF}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd1}},
			'{'{CMD_SUBMIT, 16'h0000, 16'h0000}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd2}},
			'{'{CMD_SUBMIT, 16'h0000, 16'h0001}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd3}},
			'{'{CMD_HEAD,   16'h0000, 16'h0000}, 1,  1'b0, '0},
			'{'{CMD_TAIL,   16'h0000, 16'h0000}, 1,  1'b1, '{ST_DONE,  16'hFFFF, 16'hFFFF, 5'd1}},
			'{'{CMD_HEAD,   16'h0000, 16'h0000}, 1,  1'b0, '0},
			'{'{CMD_SUBMIT, 16'h8000, 16'hAAAA}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd1}},
			'{'{CMD_SUBMIT, 16'h8000, 16'h5555}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd2}},
			'{'{CMD_SUBMIT, 16'h7FFF, 16'h0001}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd3}},
			'{'{CMD_SUBMIT, 16'h1234, 16'h00C3}, 13, 1'b0, '0},
			'{'{CMD_SUBMIT, 16'h4321, 16'hBEEF}, 1,  1'b1, '{ST_FULL,  16'h0000, 16'h0000, 5'd16}},
			'{'{CMD_UNUSED, 16'h0000, 16'h0000}, 1,  1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd16}},
			'{'{CMD_TAIL,   16'h0000, 16'h0000}, 1,  1'b0, '0}
		};
		idle_tab  = '{0, 73, 0, 27};
		stall_tab = '{0, 0, 73, 27};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			repeat (plan[i].reps) offer(plan[i].req, plan[i].pinned, plan[i].rsp);

		// random part: runs of fill-heavy or drain-heavy traffic so the queue
		// swings between empty and full; small keys make ties common
		for (int ph = 0; ph < 5; ph++) begin
			if (ph < 4) begin
				idle_pct  = idle_tab[ph];
				stall_pct = stall_tab[ph];
			end else begin
				// receiver holds off while the sender keeps pushing
				idle_pct  = 0;
				stall_pct = 0;
				hold_asks++;
			end
			fill_pct = 50;
			for (int k = 0; k < (ph < 4 ? PHASE_REQS : HOLD_REQS); k++) begin
				if (k % 30 == 0)
					fill_pct = $urandom_range(1) ? 75 : 25;
				pick = $urandom_range(99);
				if (pick < 5)
					r.command = CMD_UNUSED;
				else if (pick < 5 + fill_pct * 95 / 100)
					r.command = CMD_SUBMIT;
				else
					r.command = $urandom_range(1) ? CMD_HEAD : CMD_TAIL;
				case ($urandom_range(3))
					0, 1: r.task_len = 16'($urandom_range(7));
					2: r.task_len = 16'($urandom());
					default: r.task_len = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				endcase
				r.task_tag = 16'($urandom());
				offer(r, 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		// drain: wait until every request has been checked; the extra wait after it catches any stray response
		while (note_q.size() != 0 || reply_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_sorted_double_ended_task_queue: clean");
		end else begin
			$display("tb_sorted_double_ended_task_queue: errors");
		end
		$finish;
	end

endmodule
